// ===== design/lmd_pkg.sv =====
// ----------------------------------------------------------------------------
// LC-3b datapath package
// Word types, decoded microinstruction layout and shared constants.
// ----------------------------------------------------------------------------
package lmd_pkg;

   localparam int REG_COUNT    = 8;
   localparam int MICRO_STATES = 64;

   localparam logic [15:0] START_ADDRESS_RESET = 16'h3000;
   localparam logic [15:0] PROT_LIMIT_RESET    = 16'h3000;
   localparam logic [7:0]  INT_VECTOR_RESET    = 8'h01;
   localparam logic [15:0] PSR_RESET           = 16'h8002;
   localparam logic [15:0] SSP_RESET           = 16'h3000;
   localparam logic [15:0] VECTOR_BASE         = 16'h0200;
   localparam logic [15:0] PSR_CC_CLEAR_MASK   = 16'hFFF8;
   localparam logic [15:0] PSR_USER_CLEAR_MASK = 16'h7FFF;
   localparam logic [7:0]  VEC_ILLEGAL         = 8'h04;
   localparam logic [7:0]  VEC_UNALIGNED       = 8'h03;
   localparam logic [7:0]  VEC_PROTECTION      = 8'h02;

   // Microstates with special meaning.
   localparam logic [5:0] ST_RESET     = 6'd18;
   localparam logic [5:0] ST_EXCEPTION = 6'd48;
   localparam logic [5:0] ST_RSV_A     = 6'd10;
   localparam logic [5:0] ST_RSV_B     = 6'd11;
   localparam logic [5:0] ST_MEM_A     = 6'd50;
   localparam logic [5:0] ST_MEM_B     = 6'd45;
   localparam logic [5:0] ST_MEM_C     = 6'd33;
   localparam logic [5:0] ST_MEM_D     = 6'd23;
   localparam logic [5:0] ST_MEM_E     = 6'd35;

   // Condition codes of the sequencer.
   localparam logic [1:0] COND_NONE  = 2'd0;
   localparam logic [1:0] COND_READY = 2'd1;
   localparam logic [1:0] COND_BEN   = 2'd2;
   localparam logic [1:0] COND_IR11  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_PROT_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_INT_VECTOR    = 2'd2;

   // Microinstruction; first member sits at bit 47.
   typedef struct packed {
      logic       ird;
      logic [1:0] cond;
      logic [5:0] j;
      logic       ld_mar;
      logic       ld_mdr;
      logic       ld_ir;
      logic       ld_ben;
      logic       ld_reg;
      logic       ld_cc;
      logic       ld_pc;
      logic       ld_psr;
      logic       ld_usp;
      logic       ld_ssp;
      logic       drv_pc;
      logic       drv_mdr;
      logic       drv_alu;
      logic       drv_marmux;
      logic       drv_shf;
      logic       drv_psr;
      logic       drv_usp;
      logic       drv_ssp;
      logic       drv_vect;
      logic [1:0] psrmux;
      logic [1:0] r6mux;
      logic [1:0] pcmux;
      logic [1:0] drmux;
      logic [1:0] sr1mux;
      logic       addr1mux;
      logic [1:0] addr2mux;
      logic       marmux;
      logic [1:0] aluk;
      logic       mio_en;
      logic       r_w;
      logic       word_access;
      logic       lshf1;
   } lmd_ucode_type;

   typedef struct packed {
      logic [47:0] control_word;
      logic [15:0] mem_read_data;
      logic        mem_ready;
      logic        interrupt_request;
   } lmd_req_type;

   typedef struct packed {
      logic [15:0] bus_value;
      logic [5:0]  next_state;
      logic [15:0] mem_address;
      logic [15:0] mem_write_data;
      logic        mem_enable;
      logic        mem_write_low;
      logic        mem_write_high;
      logic [15:0] pc_value;
      logic        exception_taken;
   } lmd_rsp_type;

   typedef struct packed {
      logic [15:0] protected_limit;
      logic [7:0]  int_vector;
   } lmd_cfg_type;

endpackage

// ===== design/lmd_core.sv =====
// ----------------------------------------------------------------------------
// LC-3b datapath core
// Architectural state and the single-clock datapath and sequencer logic.
// ----------------------------------------------------------------------------
module lmd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  lmd_pkg::lmd_req_type req,
   input  lmd_pkg::lmd_cfg_type cfg,
   output lmd_pkg::lmd_rsp_type rsp
);
   import lmd_pkg::*;

   logic [15:0] regs_ff [REG_COUNT];
   logic [15:0] pc_ff, ir_ff, mar_ff, mdr_ff, psr_ff, usp_ff, ssp_ff;
   logic [2:0]  cc_ff;
   logic        ben_ff, vec_exc_ff, pend_ff;
   logic [7:0]  int_vec_ff, exc_vec_ff;
   logic [5:0]  state_ff;

   lmd_ucode_type uc;
   logic        exc, forced, prot_st, align_st;
   logic [7:0]  excv;
   logic [5:0]  nstate;
   logic [2:0]  sr1_idx, dr;
   logic [15:0] sr1_raw, sr1, off, off_sh, adder, sr2, alu, shf, mdrg, vect, bus;
   logic [15:0] pc_in, mdr_in, psr_in;
   logic [2:0]  cc_ld, cc_in;
   logic        n_flag, z_flag;

   assign uc = lmd_ucode_type'(req.control_word);

   // Exception detection on the current microstate.
   assign prot_st  = (state_ff == ST_MEM_A) || (state_ff == ST_MEM_B) ||
                     (state_ff == ST_MEM_C) || (state_ff == ST_MEM_D) ||
                     (state_ff == ST_MEM_E);
   assign align_st = (state_ff == ST_MEM_B) || (state_ff == ST_MEM_D) ||
                     (state_ff == ST_MEM_A);

   always_comb begin
      exc  = pend_ff;
      excv = exc_vec_ff;
      if (psr_ff[15] && (mar_ff < cfg.protected_limit) && prot_st) begin
         exc  = 1'b1;
         excv = VEC_PROTECTION;
      end else if (mar_ff[0] && align_st) begin
         exc  = 1'b1;
         excv = VEC_UNALIGNED;
      end
   end

   // Next microstate.
   always_comb begin
      if (uc.ird) begin
         nstate = {2'b00, ir_ff[15:12]};
      end else begin
         nstate = uc.j;
         unique case (uc.cond)
            COND_NONE:  ;
            COND_READY: nstate[1] = nstate[1] | req.mem_ready;
            COND_BEN:   nstate[2] = nstate[2] | ben_ff;
            COND_IR11:  nstate[0] = nstate[0] | ir_ff[11];
            default:    ;
         endcase
      end
      forced = exc | req.interrupt_request;
      if (forced) nstate = ST_EXCEPTION;
   end

   // Source register and stack adjust.
   always_comb begin
      unique case (uc.sr1mux)
         2'd0:    sr1_idx = ir_ff[11:9];
         2'd1:    sr1_idx = ir_ff[8:6];
         default: sr1_idx = 3'd6;
      endcase
      sr1_raw = regs_ff[sr1_idx];
      unique case (uc.r6mux)
         2'd0:    sr1 = sr1_raw;
         2'd1:    sr1 = sr1_raw + 16'd2;
         default: sr1 = sr1_raw - 16'd2;
      endcase
   end

   // Address adder.
   always_comb begin
      unique case (uc.addr2mux)
         2'd0:    off = 16'd0;
         2'd1:    off = {{10{ir_ff[5]}}, ir_ff[5:0]};
         2'd2:    off = {{7{ir_ff[8]}}, ir_ff[8:0]};
         default: off = {{5{ir_ff[10]}}, ir_ff[10:0]};
      endcase
      off_sh = uc.lshf1 ? {off[14:0], 1'b0} : off;
      adder  = off_sh + (uc.addr1mux ? sr1 : pc_ff);
   end

   // ALU and shifter.
   always_comb begin
      sr2 = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];
      unique case (uc.aluk)
         2'd0:    alu = sr1 + sr2;
         2'd1:    alu = sr1 & sr2;
         2'd2:    alu = sr1 ^ sr2;
         default: alu = sr1;
      endcase
      if (ir_ff[5:4] == 2'd0) shf = sr1 << ir_ff[3:0];
      else if (ir_ff[5])      shf = 16'($signed(sr1) >>> ir_ff[3:0]);
      else                    shf = sr1 >> ir_ff[3:0];
   end

   // MDR byte select, vector and bus priority.
   always_comb begin
      if (uc.word_access) mdrg = mdr_ff;
      else if (mar_ff[0]) mdrg = {{8{mdr_ff[15]}}, mdr_ff[15:8]};
      else                mdrg = {{8{mdr_ff[7]}}, mdr_ff[7:0]};
      vect = VECTOR_BASE + {7'd0, (vec_exc_ff ? excv : int_vec_ff), 1'b0};
      priority if (uc.drv_pc)      bus = pc_ff;
      else if (uc.drv_marmux)      bus = uc.marmux ? adder : {7'd0, ir_ff[7:0], 1'b0};
      else if (uc.drv_alu)         bus = alu;
      else if (uc.drv_shf)         bus = shf;
      else if (uc.drv_mdr)         bus = mdrg;
      else if (uc.drv_usp)         bus = usp_ff;
      else if (uc.drv_ssp)         bus = ssp_ff;
      else if (uc.drv_psr)         bus = psr_ff;
      else if (uc.drv_vect)        bus = vect;
      else                         bus = 16'd0;
   end

   // Next values of PC, MDR, condition codes and PSR.
   always_comb begin
      unique case (uc.pcmux)
         2'd0:    pc_in = pc_ff + 16'd2;
         2'd1:    pc_in = bus;
         2'd2:    pc_in = adder;
         default: pc_in = pc_ff - 16'd2;
      endcase
      if (!uc.ld_pc) pc_in = pc_ff;

      mdr_in = mdr_ff;
      if (uc.ld_mdr) begin
         if (!uc.mio_en)
            mdr_in = mar_ff[0] ? {bus[7:0], bus[7:0]} : bus;
         else if (!uc.r_w && req.mem_ready)
            mdr_in = req.mem_read_data;
      end

      n_flag = bus[15];
      z_flag = (bus == 16'd0);
      cc_ld  = uc.ld_cc ? {n_flag, z_flag, !n_flag && !z_flag} : cc_ff;
      cc_in  = cc_ld;
      psr_in = psr_ff;
      if (uc.ld_psr) begin
         unique case (uc.psrmux)
            2'd0: begin
               psr_in = bus;
               cc_in  = bus[2:0];
            end
            2'd1:    psr_in = (psr_ff & PSR_CC_CLEAR_MASK) | {13'd0, cc_ld};
            2'd2:    psr_in = psr_ff & PSR_USER_CLEAR_MASK;
            default: ;
         endcase
      end

      unique case (uc.drmux)
         2'd0:    dr = ir_ff[11:9];
         2'd1:    dr = 3'd7;
         default: dr = 3'd6;
      endcase
   end

   // Architectural state update, one microinstruction per step.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= 16'd0;
         pc_ff      <= START_ADDRESS_RESET;
         ir_ff      <= 16'd0;
         mar_ff     <= 16'd0;
         mdr_ff     <= 16'd0;
         cc_ff      <= 3'b010;
         ben_ff     <= 1'b0;
         psr_ff     <= PSR_RESET;
         usp_ff     <= 16'd0;
         ssp_ff     <= SSP_RESET;
         int_vec_ff <= 8'd0;
         exc_vec_ff <= 8'd0;
         vec_exc_ff <= 1'b0;
         pend_ff    <= 1'b0;
         state_ff   <= ST_RESET;
      end else if (step) begin
         if (uc.ld_mar) mar_ff <= bus;
         if (uc.ld_ir)  ir_ff  <= bus;
         if (uc.ld_ben)
            ben_ff <= (ir_ff[11] & cc_ff[2]) | (ir_ff[10] & cc_ff[1]) | (ir_ff[9] & cc_ff[0]);
         if (uc.ld_reg) regs_ff[dr] <= bus;
         if (uc.ld_usp) usp_ff <= sr1;
         if (uc.ld_ssp) ssp_ff <= sr1;
         mdr_ff <= mdr_in;
         pc_ff  <= pc_in;
         cc_ff  <= cc_in;
         psr_ff <= psr_in;
         if (exc)                        vec_exc_ff <= 1'b1;
         else if (req.interrupt_request) vec_exc_ff <= 1'b0;
         if (req.interrupt_request) int_vec_ff <= cfg.int_vector;
         // Reserved opcodes register a pending trap with the illegal-opcode vector; it is taken at the next step.
         if (nstate == ST_RSV_A || nstate == ST_RSV_B) begin
            exc_vec_ff <= VEC_ILLEGAL;
            pend_ff    <= 1'b1;
         end else begin
            exc_vec_ff <= excv;
            pend_ff    <= 1'b0;
         end
         state_ff <= nstate;
      end
   end

   // Result word.
   always_comb begin
      rsp.bus_value       = bus;
      rsp.next_state      = nstate;
      rsp.mem_address     = mar_ff;
      rsp.mem_write_data  = mdr_ff;
      rsp.mem_enable      = uc.mio_en;
      rsp.mem_write_low   = uc.mio_en & uc.r_w & (uc.word_access | !mar_ff[0]);
      rsp.mem_write_high  = uc.mio_en & uc.r_w & (uc.word_access | mar_ff[0]);
      rsp.pc_value        = pc_in;
      rsp.exception_taken = forced;
   end

endmodule

// ===== design/lc3b_microcoded_datapath_unit.sv =====
// ----------------------------------------------------------------------------
// LC-3b microcoded datapath unit
// One request word is one microinstruction clock of the LC-3b datapath.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries the control word of the current microstate,
// memory read data, memory ready and an interrupt request. Each request
// word yields exactly one response word with the bus value, next microstate,
// memory controls and the program counter after that clock.
// A request is captured in an input register; the datapath then evaluates it,
// updates the architectural state and loads the response register as soon as
// the response register is empty or its word is being taken. One word is taken
// every cycle while the response side keeps up.
// When the receiver stalls, the response register holds its word and the
// input register holds the next one; the request side is stalled only when
// both are occupied.
// Reset clears both registers and puts the architectural state at its
// power-up values (PC 0x3000, microstate 18). The CSR port sets the
// protection limit and the interrupt vector; the start address write is
// accepted and the program counter always restarts at its reset value.
// ----------------------------------------------------------------------------
module lc3b_microcoded_datapath_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lmd_pkg::lmd_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lmd_pkg::lmd_rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data
);
   import lmd_pkg::*;

   logic        in_valid_ff, rsp_valid_ff, step;
   lmd_req_type in_ff;
   lmd_rsp_type rsp_ff, core_rsp;
   lmd_cfg_type cfg_ff;

   assign step      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protected_limit <= PROT_LIMIT_RESET;
         cfg_ff.int_vector      <= INT_VECTOR_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_PROT_LIMIT) cfg_ff.protected_limit <= csr_write_data;
         if (csr_index == CSR_INT_VECTOR) cfg_ff.int_vector <= csr_write_data[7:0];
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) in_ff <= req_payload;
   end

   lmd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step) rsp_ff <= core_rsp;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/lmd_checker.sv =====
// ----------------------------------------------------------------------------
// LC-3b datapath port checker
// Port-level properties of the datapath unit, bound to the top level.
// ----------------------------------------------------------------------------
module lmd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lmd_pkg::lmd_rsp_type rsp_payload
);
   import lmd_pkg::*;

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response word changed while stalled");

   // No response word right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A redirect always goes to the exception microstate.
   a_exc_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.exception_taken |-> rsp_payload.next_state == ST_EXCEPTION)
      else $error("exception without exception microstate");

   // Byte write enables only with a memory access.
   a_write_en: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.mem_write_low || rsp_payload.mem_write_high)
      |-> rsp_payload.mem_enable)
      else $error("write enable without memory access");

endmodule

bind lc3b_microcoded_datapath_unit lmd_checker u_lmd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
